@@ rtl/tmb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_pkg
// Shared types and codes for the timer bank: command and result transactions,
// command kinds and status codes.
// ----------------------------------------------------------------------------
package tmb_pkg;

	localparam int unsigned NUM_TIMERS_DEF = 16;
	localparam int unsigned MAX_REPORTS    = 16;
	localparam int unsigned RPT_W          = $clog2(MAX_REPORTS + 1);

	localparam logic [2:0] KIND_SET   = 3'd0;
	localparam logic [2:0] KIND_FREE  = 3'd1;
	localparam logic [2:0] KIND_PAUSE = 3'd2;
	localparam logic [2:0] KIND_CONT  = 3'd3;
	localparam logic [2:0] KIND_RESET = 3'd4;
	localparam logic [2:0] KIND_TICK  = 3'd5;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_NO_ID = 2'd1;
	localparam logic [1:0] STS_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] target_id;
		logic [31:0] period_ms;
		logic        repeat_req;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] timer_id_res;
		logic        expired;
		logic        last;
	} res_t;

endpackage

@@ rtl/tmb_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tmb_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/timer_bank_with_pause.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_bank_with_pause
// Bank of millisecond timer slots with set, free, pause, continue, reset and
// tick commands; expiries reported in slot order.
// ----------------------------------------------------------------------------
// Every accepted transaction of kinds 0 to 5 walks all NUM_TIMERS slots through the
// slot RAM, one slot per cycle on its single read port while no earlier result blocks
// the walk, and the bank is ready again once the scan and the flush are done; the
// result side can hold the bank while an earlier result still waits in the output
// register.
// Commands give one result; a tick gives one result per expiry (at most
// MAX_REPORTS, lowest slots first) with last set on the final one, and none
// if nothing expired. Kinds 6 and 7 are dropped without a scan or a result. Used and
// running flags sit in flip-flops cleared by reset, so no clearing pass is
// needed. The next command is accepted while a result still waits to be taken.
module timer_bank_with_pause #(
	parameter int unsigned NUM_TIMERS = tmb_pkg::NUM_TIMERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  tmb_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output tmb_pkg::res_t res
);

	localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

	typedef struct packed {
		logic        rpt;
		logic [31:0] period;
		logic [31:0] remaining;
		logic [15:0] ident;
	} slot_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t                   state_q;
	tmb_pkg::cmd_t            cmd_q;
	logic [CW-1:0]            idx_q;
	logic                     ev_v_s1;
	logic [IW-1:0]            ev_idx_s1;
	logic [NUM_TIMERS-1:0]    used_q;
	logic [NUM_TIMERS-1:0]    running_q;
	logic [15:0]              next_q;
	logic [tmb_pkg::RPT_W-1:0] n_q;
	logic                     done_q;
	logic                     pend_v_q;
	tmb_pkg::res_t            pend_q;
	logic                     res_valid_q;
	tmb_pkg::res_t            res_q;

	slot_t         rd_slot;
	slot_t         wr_slot;
	logic          wr_en;
	logic [IW-1:0] rd_addr;

	logic          is_tick;
	logic          ev_active;
	logic          live;
	logic [31:0]   rem_dec;
	logic          hit;
	logic          take;
	logic          produce;
	logic          blocked;
	logic          res_free;
	logic [15:0]   next_inc;
	tmb_pkg::res_t new_res;
	tmb_pkg::res_t final_res;
	logic          final_v;
	logic          res_load;
	tmb_pkg::res_t res_load_d;

	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign res_free  = !res_valid_q || !res_stall;
	assign is_tick   = (cmd_q.kind == tmb_pkg::KIND_TICK);
	assign ev_active = (state_q == ST_SCAN) && ev_v_s1;
	assign next_inc  = next_q + 16'd1;

	always_comb begin
		live    = used_q[ev_idx_s1] && running_q[ev_idx_s1];
		rem_dec = (rd_slot.remaining != 32'd0) ? rd_slot.remaining - 32'd1 : 32'd0;
		hit     = live && (rem_dec == 32'd0);
		if (cmd_q.kind == tmb_pkg::KIND_SET) begin
			take = !done_q && !used_q[ev_idx_s1];
		end else begin
			take = !done_q && used_q[ev_idx_s1] && (rd_slot.ident == cmd_q.target_id);
		end
		if (is_tick) begin
			produce = ev_active && hit && (n_q < tmb_pkg::RPT_W'(tmb_pkg::MAX_REPORTS));
		end else begin
			produce = ev_active && take;
		end
		// a second report needs the pending one moved out first
		blocked = produce && pend_v_q && !res_free;

		new_res.status       = tmb_pkg::STS_OK;
		new_res.expired      = is_tick;
		new_res.last         = 1'b0;
		if (is_tick) begin
			new_res.timer_id_res = rd_slot.ident;
		end else if (cmd_q.kind == tmb_pkg::KIND_SET) begin
			new_res.timer_id_res = next_inc;
		end else begin
			new_res.timer_id_res = cmd_q.target_id;
		end

		wr_slot = rd_slot;
		wr_en   = 1'b0;
		if (ev_active && !blocked) begin
			if (is_tick) begin
				wr_en             = live;
				wr_slot.remaining = (hit && rd_slot.rpt) ? rd_slot.period : rem_dec;
			end else if (take && cmd_q.kind == tmb_pkg::KIND_SET) begin
				wr_en             = 1'b1;
				wr_slot.rpt       = cmd_q.repeat_req;
				wr_slot.period    = cmd_q.period_ms;
				wr_slot.remaining = cmd_q.period_ms;
				wr_slot.ident     = next_inc;
			end else if (take && cmd_q.kind == tmb_pkg::KIND_RESET) begin
				wr_en             = 1'b1;
				wr_slot.period    = cmd_q.period_ms;
				wr_slot.remaining = cmd_q.period_ms;
			end
		end

		// hold the read on the slot under evaluation while blocked
		rd_addr = blocked ? ev_idx_s1 : idx_q[IW-1:0];

		final_v = pend_v_q || !is_tick;
		if (pend_v_q) begin
			final_res      = pend_q;
			final_res.last = 1'b1;
		end else begin
			final_res.status       = (cmd_q.kind == tmb_pkg::KIND_SET) ?
				tmb_pkg::STS_FULL : tmb_pkg::STS_NO_ID;
			final_res.timer_id_res = (cmd_q.kind == tmb_pkg::KIND_SET) ?
				16'd0 : cmd_q.target_id;
			final_res.expired      = 1'b0;
			final_res.last         = 1'b1;
		end

		// output register load: an earlier report during the scan, the final one at flush
		res_load   = 1'b0;
		res_load_d = pend_q;
		if (ev_active && !blocked && produce && pend_v_q) begin
			res_load = 1'b1;
		end else if (state_q == ST_FLUSH && final_v && res_free) begin
			res_load   = 1'b1;
			res_load_d = final_res;
		end
	end

	tmb_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (NUM_TIMERS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ev_idx_s1),
		.wr_data (wr_slot),
		.rd_addr (rd_addr),
		.rd_data (rd_slot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			idx_q       <= '0;
			ev_v_s1     <= 1'b0;
			ev_idx_s1   <= '0;
			used_q      <= '0;
			running_q   <= '0;
			next_q      <= '0;
			n_q         <= '0;
			done_q      <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_q      <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) begin
				res_q       <= res_load_d;
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q    <= cmd;
						idx_q    <= '0;
						ev_v_s1  <= 1'b0;
						n_q      <= '0;
						done_q   <= 1'b0;
						pend_v_q <= 1'b0;
						if (cmd.kind <= tmb_pkg::KIND_TICK) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (!blocked) begin
						if (ev_active) begin
							if (is_tick) begin
								if (hit && !rd_slot.rpt) begin
									used_q[ev_idx_s1]    <= 1'b0;
									running_q[ev_idx_s1] <= 1'b0;
								end
							end else if (take) begin
								case (cmd_q.kind)
									tmb_pkg::KIND_SET: begin
										used_q[ev_idx_s1]    <= 1'b1;
										running_q[ev_idx_s1] <= 1'b1;
										next_q               <= next_inc;
									end
									tmb_pkg::KIND_FREE: begin
										used_q[ev_idx_s1]    <= 1'b0;
										running_q[ev_idx_s1] <= 1'b0;
									end
									tmb_pkg::KIND_PAUSE: running_q[ev_idx_s1] <= 1'b0;
									tmb_pkg::KIND_CONT:  running_q[ev_idx_s1] <= 1'b1;
									default: ;
								endcase
							end
							if (produce) begin
								pend_q   <= new_res;
								pend_v_q <= 1'b1;
								done_q   <= 1'b1;
								n_q      <= n_q + tmb_pkg::RPT_W'(1);
							end
						end
						if (idx_q != CW'(NUM_TIMERS)) begin
							ev_v_s1   <= 1'b1;
							ev_idx_s1 <= idx_q[IW-1:0];
							idx_q     <= idx_q + CW'(1);
						end else begin
							ev_v_s1 <= 1'b0;
							if (!ev_v_s1) begin
								state_q <= ST_FLUSH;
							end
						end
					end
				end
				ST_FLUSH: begin
					if (!final_v) begin
						state_q <= ST_IDLE;
					end else if (res_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ test/timer_bank_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_bank_monitor
// Watches both channels of the timer bank. It keeps its own copy of the slot
// table, works out the results of every accepted command, and compares each
// accepted result, field by field, with the oldest one still awaited.
// ----------------------------------------------------------------------------
module timer_bank_monitor #(
	parameter int unsigned NUM_TIMERS = tmb_pkg::NUM_TIMERS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  logic          cmd_stall,
	input  tmb_pkg::cmd_t cmd,
	input  logic          res_valid,
	input  logic          res_stall,
	input  tmb_pkg::res_t res,
	output int            fails,
	output int            pending
);

	logic        used    [NUM_TIMERS];
	logic        running [NUM_TIMERS];
	logic        rpt     [NUM_TIMERS];
	logic [31:0] period  [NUM_TIMERS];
	logic [31:0] remain  [NUM_TIMERS];
	logic [15:0] ident   [NUM_TIMERS];
	logic [15:0] ident_ctr;

	tmb_pkg::res_t awaited[$];
	int            miss_cnt = 0;

	assign fails = miss_cnt;

	task automatic check_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			miss_cnt++;
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
		end
	endtask

	// Updates the slot table for one command and queues what it should answer.
	task automatic step_timer_bank(input tmb_pkg::cmd_t c);
		tmb_pkg::res_t r;
		int   hit;
		int   free_slot;
		int   n;
		hit = -1;
		free_slot = -1;
		n = 0;
		r = '0;
		r.last = 1'b1;
		case (c.kind)
		tmb_pkg::KIND_SET: begin
			for (int i = NUM_TIMERS - 1; i >= 0; i--)
				if (!used[i])
					free_slot = i;
			if (free_slot < 0) begin
				r.status = tmb_pkg::STS_FULL;
			end else begin
				ident_ctr = ident_ctr + 16'd1;
				used[free_slot]    = 1'b1;
				running[free_slot] = 1'b1;
				rpt[free_slot]     = c.repeat_req;
				period[free_slot]  = c.period_ms;
				remain[free_slot]  = c.period_ms;
				ident[free_slot]   = ident_ctr;
				r.status       = tmb_pkg::STS_OK;
				r.timer_id_res = ident_ctr;
			end
			awaited.push_back(r);
		end
		tmb_pkg::KIND_FREE, tmb_pkg::KIND_PAUSE, tmb_pkg::KIND_CONT,
		tmb_pkg::KIND_RESET: begin
			// lowest matching slot wins when IDs repeat after a wrap
			for (int i = NUM_TIMERS - 1; i >= 0; i--)
				if (used[i] && ident[i] == c.target_id)
					hit = i;
			r.timer_id_res = c.target_id;
			if (hit < 0) begin
				r.status = tmb_pkg::STS_NO_ID;
			end else begin
				r.status = tmb_pkg::STS_OK;
				case (c.kind)
				tmb_pkg::KIND_FREE: begin
					used[hit]    = 1'b0;
					running[hit] = 1'b0;
				end
				tmb_pkg::KIND_PAUSE: running[hit] = 1'b0;
				tmb_pkg::KIND_CONT:  running[hit] = 1'b1;
				default: begin
					period[hit] = c.period_ms;
					remain[hit] = c.period_ms;
				end
				endcase
			end
			awaited.push_back(r);
		end
		tmb_pkg::KIND_TICK: begin
			// each expiry is held back one step so the final one can carry last
			for (int i = 0; i < NUM_TIMERS; i++) begin
				if (used[i] && running[i]) begin
					if (remain[i] != 0)
						remain[i] = remain[i] - 32'd1;
					if (remain[i] == 0) begin
						if (n < tmb_pkg::MAX_REPORTS) begin
							if (n > 0)
								awaited.push_back(r);
							r = '0;
							r.status       = tmb_pkg::STS_OK;
							r.timer_id_res = ident[i];
							r.expired      = 1'b1;
							n++;
						end
						if (rpt[i]) begin
							remain[i] = period[i];
						end else begin
							used[i]    = 1'b0;
							running[i] = 1'b0;
						end
					end
				end
			end
			if (n > 0) begin
				r.last = 1'b1;
				awaited.push_back(r);
			end
		end
		default: ;
		endcase
	endtask

	always @(posedge clk) begin
		tmb_pkg::res_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				used[i]    = 1'b0;
				running[i] = 1'b0;
			end
			ident_ctr = '0;
			awaited.delete();
			pending <= 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				step_timer_bank(cmd);
			if (res_valid && !res_stall) begin
				if (awaited.size() == 0) begin
					miss_cnt++;
					$error("unexpected result: status %0d, timer_id_res %0d",
						res.status, res.timer_id_res);
				end else begin
					want = awaited.pop_front();
					check_field("status", want.status, res.status);
					check_field("timer_id_res", want.timer_id_res, res.timer_id_res);
					check_field("expired", want.expired, res.expired);
					check_field("last", want.last, res.last);
				end
			end
			pending <= awaited.size();
		end
	end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the timer bank: a directed pass over every command and corner,
// a tick on which every slot expires, then random traffic with random idling,
// one long result hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned NUM        = 16;
	localparam int          RAND_ITEMS = 200;
	localparam int          HOLD_LEN   = 400;
	localparam int unsigned RUN_LIMIT  = 500_000;
	localparam logic [2:0]  KIND_NOP6  = 3'd6;
	localparam logic [2:0]  KIND_NOP7  = 3'd7;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           cmd_valid = 1'b0;
	logic           cmd_stall;
	tmb_pkg::cmd_t  cmd       = '0;
	logic           res_valid;
	logic           res_stall = 1'b0;
	tmb_pkg::res_t  res;

	int    fails;
	int    pending;
	logic  quiet     = 1'b0;
	logic  hold_req  = 1'b0;
	logic  hold_seen = 1'b0;
	int    hold_left = 0;
	int    id_seq    = 0;
	int unsigned cycles = 0;

	always #5 clk = ~clk;

	timer_bank_with_pause #(.NUM_TIMERS(NUM)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	timer_bank_monitor #(.NUM_TIMERS(NUM)) mon (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.fails     (fails),
		.pending   (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("timer_bank_with_pause: mismatch");
			$finish;
		end
	end

	// result side: random stall, or a long hold when the stimulus toggles hold_req
	always @(posedge clk) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_LEN;
			res_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= !quiet && ($urandom_range(99) < 37);
		end
	end

	task automatic offer(input logic [2:0] kind, input logic [15:0] tid,
			input logic [31:0] per, input logic rep);
		while (!quiet && $urandom_range(99) < 37) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= '{kind, tid, per, rep};
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// mostly IDs handed out recently, so that commands find live timers
	function automatic logic [15:0] near_id();
		if ($urandom_range(4) == 0)
			return 16'($urandom);
		return 16'(id_seq - int'($urandom_range(20)));
	endfunction

	function automatic logic [31:0] rand_period();
		case ($urandom_range(9))
		6, 7:    return 32'($urandom_range(40, 6));
		8:       return $urandom;
		9:       return 32'hFFFF_FFFF;
		default: return 32'($urandom_range(5));
		endcase
	endfunction

	initial begin : stimulus
		int  r;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ID 1 stays in slot 0, paused
		offer(tmb_pkg::KIND_SET, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
		offer(tmb_pkg::KIND_PAUSE, 16'd1, '0, 1'b0);
		offer(tmb_pkg::KIND_TICK, '0, '0, 1'b0);
		offer(KIND_NOP6, 16'd1, '0, 1'b0);
		offer(KIND_NOP7, 16'd1, '0, 1'b0);
		offer(tmb_pkg::KIND_FREE, 16'h1234, '0, 1'b0);
		offer(tmb_pkg::KIND_CONT, 16'h0000, '0, 1'b0);
		// zero period, one-shot then repeating
		offer(tmb_pkg::KIND_SET, '0, '0, 1'b0);
		offer(tmb_pkg::KIND_TICK, '0, '0, 1'b0);
		offer(tmb_pkg::KIND_SET, '0, '0, 1'b1);
		offer(tmb_pkg::KIND_TICK, '0, '0, 1'b0);
		offer(tmb_pkg::KIND_TICK, '0, '0, 1'b0);
		offer(tmb_pkg::KIND_SET, '0, 32'd3, 1'b0);
		offer(tmb_pkg::KIND_PAUSE, 16'd4, '0, 1'b0);
		offer(tmb_pkg::KIND_PAUSE, 16'd4, '0, 1'b0);
		offer(tmb_pkg::KIND_TICK, '0, '0, 1'b0);
		offer(tmb_pkg::KIND_CONT, 16'd4, '0, 1'b0);
		offer(tmb_pkg::KIND_CONT, 16'd4, '0, 1'b0);
		offer(tmb_pkg::KIND_RESET, 16'd4, 32'd1, 1'b0);
		offer(tmb_pkg::KIND_TICK, '0, '0, 1'b0);
		// reset on a paused timer leaves it paused
		offer(tmb_pkg::KIND_RESET, 16'd1, '0, 1'b0);
		offer(tmb_pkg::KIND_TICK, '0, '0, 1'b0);
		offer(tmb_pkg::KIND_FREE, 16'd3, '0, 1'b0);
		offer(tmb_pkg::KIND_FREE, 16'd3, '0, 1'b0);
		offer(tmb_pkg::KIND_RESET, 16'hBEEF, 32'd7, 1'b0);
		offer(tmb_pkg::KIND_PAUSE, 16'h7777, '0, 1'b0);
		id_seq = 4;
		drain();

		// ID 1 resumes with a zero period and the other slots fill up with
		// zero-period one-shots, so every slot expires on one tick
		offer(tmb_pkg::KIND_CONT, 16'd1, '0, 1'b0);
		repeat (NUM - 1) begin
			offer(tmb_pkg::KIND_SET, 16'($urandom), '0, 1'b0);
			id_seq++;
		end
		offer(tmb_pkg::KIND_SET, 16'($urandom), 32'($urandom), 1'b1);
		offer(tmb_pkg::KIND_TICK, '0, '0, 1'b0);
		offer(tmb_pkg::KIND_FREE, 16'd1, '0, 1'b0);
		drain();

		for (int k = 0; k < RAND_ITEMS; k++) begin
			if (k == 60)
				hold_req <= ~hold_req;
			if (k == 120)
				drain();
			quiet <= (k >= 140 && k < 180);
			r = $urandom_range(99);
			if (r < 22) begin
				offer(tmb_pkg::KIND_SET, 16'($urandom), rand_period(),
					1'($urandom_range(1)));
				id_seq++;
			end else if (r < 34) begin
				offer(tmb_pkg::KIND_FREE, near_id(), rand_period(), 1'($urandom_range(1)));
			end else if (r < 44) begin
				offer(tmb_pkg::KIND_PAUSE, near_id(), rand_period(), 1'($urandom_range(1)));
			end else if (r < 54) begin
				offer(tmb_pkg::KIND_CONT, near_id(), rand_period(), 1'($urandom_range(1)));
			end else if (r < 64) begin
				offer(tmb_pkg::KIND_RESET, near_id(), rand_period(), 1'($urandom_range(1)));
			end else if (r < 96) begin
				offer(tmb_pkg::KIND_TICK, 16'($urandom), $urandom, 1'($urandom_range(1)));
			end else begin
				offer($urandom_range(1) ? KIND_NOP6 : KIND_NOP7, 16'($urandom),
					$urandom, 1'($urandom_range(1)));
			end
		end
		quiet <= 1'b0;
		drain();
		repeat (40) @(posedge clk);

		if (fails == 0 && pending == 0)
			$display("timer_bank_with_pause: match");
		else
			$display("timer_bank_with_pause: mismatch");
		$finish;
	end

endmodule
